>>> rtl/pim_row_gate_array_wear_renaming_top_macros.svh
// assertion helpers used by prgawr_back
`ifndef PIM_ROW_GATE_ARRAY_WEAR_RENAMING_TOP_MACROS_SVH
`define PIM_ROW_GATE_ARRAY_WEAR_RENAMING_TOP_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PRGAWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be true outside reset
`define PRGAWR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/prgawr_pkg.sv
// ----------------------------------------------------------------------------
// prgawr_pkg
// Types and constants of the compute-in-memory row gate array.
// ----------------------------------------------------------------------------
package prgawr_pkg;

  localparam int PHYS_ROWS  = 64;
  localparam int PHYS_COLS  = 32;
  localparam int SPARE_ROWS = 4;
  localparam int LOG_ROWS   = PHYS_ROWS - SPARE_ROWS;

  localparam int ROW_W   = $clog2(PHYS_ROWS);
  localparam int LROW_W  = $clog2(LOG_ROWS);
  localparam int SPARE_W = $clog2(SPARE_ROWS);
  localparam int PC_W    = $clog2(PHYS_COLS + 1);
  localparam int FIELD_W = 32;
  localparam int OP_W    = 3;
  localparam int IROW_W  = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] COL_LIMIT = FIELD_W'((64'd1 << PHYS_COLS) - 64'd1);

  typedef enum logic [OP_W-1:0] {
    OP_NOT   = 3'd0,
    OP_NAND  = 3'd1,
    OP_AND   = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RENAME_EN = 2'd0,
    CFG_PERIOD    = 2'd1,
    CFG_FULL_COLS = 2'd2,
    CFG_BUDGET    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    B_IDLE, B_MAP_T, B_MAP_A, B_MAP_B, B_CELL_A, B_CELL_B, B_CELL_T, B_WB
  } back_state_e;

  typedef struct packed {
    logic        rename_en;
    logic [15:0] period;
    logic [5:0]  full_cols;
    logic [31:0] budget;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] mask;
    logic [IROW_W-1:0]  ra;
    logic [IROW_W-1:0]  rb;
    logic [IROW_W-1:0]  rt;
    logic [FIELD_W-1:0] wbits;
    logic               bad;
    logic               counted;
  } item_t;

endpackage

>>> rtl/prgawr_if.sv
// ----------------------------------------------------------------------------
// prgawr channel interfaces
// Operation, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface prgawr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] col_mask;
  logic [5:0]  src_row_a;
  logic [5:0]  src_row_b;
  logic [5:0]  target_row;
  logic [31:0] write_bits;
  modport source (output valid, op, col_mask, src_row_a, src_row_b, target_row,
                  write_bits, input ready);
  modport sink (input valid, op, col_mask, src_row_a, src_row_b, target_row,
                write_bits, output ready);
endinterface

interface prgawr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_bits;
  logic [31:0] worn_mask;
  modport source (output valid, read_bits, worn_mask, input ready);
  modport sink (input valid, read_bits, worn_mask, output ready);
endinterface

interface prgawr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/prgawr_fifo.sv
// ----------------------------------------------------------------------------
// prgawr_fifo
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module prgawr_fifo
  import prgawr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t pop_data_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

>>> rtl/prgawr_front.sv
// ----------------------------------------------------------------------------
// prgawr_front
// Accepts operation beats, checks rows and ops, counts masked columns.
// ----------------------------------------------------------------------------
module prgawr_front
  import prgawr_pkg::*;
(
  prgawr_in_if.sink in_i,
  input  logic [5:0] full_cols_i,
  input  logic       q_full_i,
  output logic       push_o,
  output item_t      item_o
);

  logic [FIELD_W-1:0] mask;
  logic [PC_W-1:0]    pop_cnt;
  logic               gate_op, two_src;

  always_comb begin
    mask    = in_i.col_mask & COL_LIMIT;
    pop_cnt = '0;
    for (int i = 0; i < PHYS_COLS; i++) begin
      pop_cnt = pop_cnt + PC_W'(mask[i]);
    end
    gate_op = (in_i.op == OP_NOT) || (in_i.op == OP_NAND) || (in_i.op == OP_AND);
    two_src = (in_i.op == OP_NAND) || (in_i.op == OP_AND);

    item_o.op      = in_i.op;
    item_o.mask    = mask;
    item_o.ra      = in_i.src_row_a;
    item_o.rb      = in_i.src_row_b;
    item_o.rt      = in_i.target_row;
    item_o.wbits   = in_i.write_bits;
    item_o.bad     = (in_i.op > OP_READ)
                  || (32'(in_i.target_row) >= LOG_ROWS)
                  || (gate_op && (32'(in_i.src_row_a) >= LOG_ROWS))
                  || (two_src && (32'(in_i.src_row_b) >= LOG_ROWS));
    item_o.counted = 32'(pop_cnt) >= 32'(full_cols_i);
  end

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

endmodule

>>> rtl/prgawr_back.sv
// ----------------------------------------------------------------------------
// prgawr_back
// Row map, renaming, gate evaluation, cell and wear memories, result register.
// ----------------------------------------------------------------------------
`include "pim_row_gate_array_wear_renaming_top_macros.svh"

module prgawr_back
  import prgawr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_data_i,
  output logic  q_pop_o,
  prgawr_out_if.source out_o
);

  back_state_e state_q, state_d;
  item_t       item_q, item_d;
  logic [ROW_W-1:0]   pt_q, pt_d, pa_q, pa_d, pb_q, pb_d;
  logic [FIELD_W-1:0] a_q, a_d, b_q, b_d;
  logic [15:0]        cnt_q, cnt_d;
  logic [ROW_W-1:0]   spare_q [SPARE_ROWS];
  logic [ROW_W-1:0]   spare_d [SPARE_ROWS];
  logic [SPARE_W-1:0] head_q, head_d;

  // row map memory with per-entry valid, invalid reads as identity
  logic [ROW_W-1:0]  map_mem [LOG_ROWS];
  logic [LOG_ROWS-1:0] map_vld_q;
  logic              map_re, map_we;
  logic [LROW_W-1:0] map_ra, map_wa;
  logic [ROW_W-1:0]  map_wd, map_rd_q;

  // cell and wear memories, invalid rows read as zero
  logic [FIELD_W-1:0] cell_mem [PHYS_ROWS];
  logic [PHYS_ROWS-1:0] cell_vld_q;
  logic               cell_re, cell_we;
  logic [ROW_W-1:0]   cell_ra;
  logic [FIELD_W-1:0] cell_wd, cell_rd_q;

  logic [PHYS_COLS-1:0][31:0] wear_mem [PHYS_ROWS];
  logic [PHYS_ROWS-1:0]       wear_vld_q;
  logic                       wear_re;
  logic [PHYS_COLS-1:0][31:0] wear_wd, wear_rd_q;

  logic               out_vld_q, out_free, res_push;
  logic [FIELD_W-1:0] out_rd_q, out_worn_q, res_rd, res_worn;

  logic [ROW_W-1:0]   old_pt;
  logic [16:0]        cnt_inc;
  logic               is_wr;
  logic [FIELD_W-1:0] val;

  assign out_free = !out_vld_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    pt_d    = pt_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    a_d     = a_q;
    b_d     = b_q;
    cnt_d   = cnt_q;
    spare_d = spare_q;
    head_d  = head_q;
    q_pop_o = 1'b0;
    map_re  = 1'b0;
    map_ra  = LROW_W'(item_q.rt);
    map_we  = 1'b0;
    map_wa  = LROW_W'(item_q.rt);
    map_wd  = spare_q[head_q];
    cell_re = 1'b0;
    cell_ra = pt_q;
    cell_we = 1'b0;
    wear_re = 1'b0;
    res_push = 1'b0;
    old_pt  = cfg_i.rename_en ? map_rd_q : ROW_W'(item_q.rt);
    cnt_inc = {1'b0, cnt_q} + 17'd1;
    is_wr   = !item_q.bad && (item_q.op != OP_READ);

    case (item_q.op)
      OP_WRITE: val = item_q.wbits;
      OP_NOT:   val = ~a_q;
      OP_NAND:  val = ~(a_q & b_q);
      default:  val = a_q & b_q;
    endcase
    cell_wd  = (cell_rd_q & ~item_q.mask) | (val & item_q.mask);
    res_worn = '0;
    for (int c = 0; c < PHYS_COLS; c++) begin
      wear_wd[c] = wear_rd_q[c];
      if (item_q.mask[c] && is_wr && (wear_rd_q[c] < cfg_i.budget)) begin
        wear_wd[c] = wear_rd_q[c] + 32'd1;
      end
      res_worn[c] = item_q.mask[c] && (wear_wd[c] >= cfg_i.budget);
    end
    res_rd = (item_q.op == OP_READ) ? (cell_rd_q & item_q.mask) : '0;
    if (item_q.bad) begin
      res_rd   = '0;
      res_worn = '0;
    end

    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_data_i;
          state_d = q_data_i.bad ? B_WB : B_MAP_T;
        end
      end
      B_MAP_T: begin
        map_re  = 1'b1;
        state_d = B_MAP_A;
      end
      B_MAP_A: begin
        pt_d = old_pt;
        if (cfg_i.rename_en && item_q.counted && (item_q.op != OP_READ)) begin
          if (cnt_inc >= {1'b0, cfg_i.period}) begin
            // period reached: swap target row with the spare queue head
            cnt_d           = '0;
            pt_d            = spare_q[head_q];
            map_we          = 1'b1;
            spare_d[head_q] = old_pt;
            head_d = (32'(head_q) == SPARE_ROWS - 1) ? '0 : head_q + SPARE_W'(1);
          end else begin
            cnt_d = cnt_inc[15:0];
          end
        end
        map_re = 1'b1;
        if (item_q.op == OP_READ || item_q.op == OP_WRITE) begin
          state_d = B_CELL_T;
        end else begin
          map_ra  = LROW_W'(item_q.ra);
          state_d = B_MAP_B;
        end
      end
      B_MAP_B: begin
        // read of a row just remapped takes the new physical row
        pa_d = (item_q.ra == item_q.rt) ? pt_q
             : (cfg_i.rename_en ? map_rd_q : ROW_W'(item_q.ra));
        map_re = 1'b1;
        if (item_q.op != OP_NOT) begin
          map_ra = LROW_W'(item_q.rb);
        end
        state_d = B_CELL_A;
      end
      B_CELL_A: begin
        pb_d = (item_q.rb == item_q.rt) ? pt_q
             : (cfg_i.rename_en ? map_rd_q : ROW_W'(item_q.rb));
        cell_re = 1'b1;
        cell_ra = pa_q;
        state_d = B_CELL_B;
      end
      B_CELL_B: begin
        a_d     = cell_rd_q;
        cell_re = 1'b1;
        cell_ra = pb_q;
        state_d = B_CELL_T;
      end
      B_CELL_T: begin
        if (item_q.op == OP_NAND || item_q.op == OP_AND) begin
          b_d = cell_rd_q;
        end
        cell_re = 1'b1;
        wear_re = 1'b1;
        state_d = B_WB;
      end
      B_WB: begin
        if (out_free) begin
          res_push = 1'b1;
          cell_we  = is_wr;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      cnt_q      <= '0;
      head_q     <= '0;
      for (int i = 0; i < SPARE_ROWS; i++) begin
        spare_q[i] <= ROW_W'(LOG_ROWS + i);
      end
      map_vld_q  <= '0;
      cell_vld_q <= '0;
      wear_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      spare_q <= spare_d;
      if (map_we) begin
        map_vld_q[map_wa] <= 1'b1;
      end
      if (cell_we) begin
        cell_vld_q[pt_q] <= 1'b1;
        wear_vld_q[pt_q] <= 1'b1;
      end
      if (res_push) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pt_q   <= pt_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    a_q    <= a_d;
    b_q    <= b_d;
    if (res_push) begin
      out_rd_q   <= res_rd;
      out_worn_q <= res_worn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd_q <= map_vld_q[map_ra] ? map_mem[map_ra] : ROW_W'(map_ra);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[pt_q] <= cell_wd;
    end
    if (cell_re) begin
      cell_rd_q <= cell_vld_q[cell_ra] ? cell_mem[cell_ra] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      wear_mem[pt_q] <= wear_wd;
    end
    if (wear_re) begin
      wear_rd_q <= wear_vld_q[pt_q] ? wear_mem[pt_q] : '0;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.read_bits = out_rd_q;
  assign out_o.worn_mask = out_worn_q;

  `PRGAWR_ASSERT(a_map_wr_in_rename, map_we |-> (state_q == B_MAP_A), "row map written outside rename step")
  `PRGAWR_ASSERT(a_rename_moves_head, map_we |=> (head_q != $past(head_q)) || (SPARE_ROWS == 1), "spare head did not advance")
  `PRGAWR_ASSERT_NEVER(a_wr_blocked_out, cell_we && !out_free, "write-back while result slot busy")
  `PRGAWR_ASSERT_NEVER(a_pop_busy, q_pop_o && (state_q != B_IDLE), "queue popped while busy")

endmodule

>>> rtl/pim_row_gate_array_wear_renaming_top.sv
// ----------------------------------------------------------------------------
// pim_row_gate_array_wear_renaming_top
// Bit-array compute-in-memory block with wear counters and row renaming.
// ----------------------------------------------------------------------------
// in_i carries one operation per beat (not, nand, and, immediate write, read)
// with a column mask and logical rows; out_o returns one beat per operation
// with the read bits and the worn-cell mask of the target row. cfg_i writes
// the four registers (rename enable, period, full-width column count, switch
// budget) and is always ready; write it only while no operation is pending.
// The front checks and classifies each beat into a two-entry queue, so it
// keeps accepting while the back is busy. The back handles one operation at
// a time through row map, cell and wear memories: a gate walks the target,
// source a and source b map reads, both source cell reads, the target cell
// and wear read, then write-back, which sets the result register valid;
// write or read skips the source steps, a rejected operation goes straight
// to write-back. The cell memory port allows one row read per cycle.
// Reset clears cells and wear through row valid bits, sets the row map to
// identity and the spare queue to rows 60..63; no clearing pass is needed.
// When out_o stalls, the result register holds, the back waits in
// write-back, and in_i drops ready once the queue fills.
module pim_row_gate_array_wear_renaming_top
  import prgawr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  prgawr_in_if.sink    in_i,
  prgawr_out_if.source out_o,
  prgawr_cfg_if.sink   cfg_i
);

  cfg_t  cfg_q, cfg_d;
  logic  push, q_full, q_valid, q_pop;
  item_t push_item, pop_item;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_RENAME_EN: cfg_d.rename_en = cfg_i.data[0];
        CFG_PERIOD:    cfg_d.period    = cfg_i.data[15:0];
        CFG_FULL_COLS: cfg_d.full_cols = cfg_i.data[5:0];
        CFG_BUDGET:    cfg_d.budget    = cfg_i.data;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rename_en <= 1'b0;
      cfg_q.period    <= 16'd100;
      cfg_q.full_cols <= 6'd32;
      cfg_q.budget    <= 32'd1000000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  prgawr_front u_front (
    .in_i        (in_i),
    .full_cols_i (cfg_q.full_cols),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  prgawr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_item)
  );

  prgawr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (pop_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

>>> test/prgawr_tb_if.sv
// ----------------------------------------------------------------------------
// prgawr testbench interfaces
// The block's channel interfaces come from the rtl; this file keeps the
// interface slot of the test folder and holds the beat record types.
// ----------------------------------------------------------------------------
package prgawr_tb_pkg;
  import prgawr_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] mask;
    logic [5:0]  ra;
    logic [5:0]  rb;
    logic [5:0]  rt;
    logic [31:0] wbits;
    logic        chk;
    logic [31:0] exp_rd;
    logic [31:0] exp_worn;
  } gate_beat_t;

  typedef struct {
    logic [31:0] rd;
    logic [31:0] worn;
  } gate_result_t;
endpackage

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives gate, write and read beats into the row gate array, keeps a bit
// level copy of cells, wear counters and row renaming, and checks every
// result beat in order, under random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import prgawr_pkg::*;
  import prgawr_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  prgawr_in_if  in_ch();
  prgawr_out_if out_ch();
  prgawr_cfg_if cfg_ch();

  pim_row_gate_array_wear_renaming_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic [31:0] m_cells [PHYS_ROWS];
  logic [31:0] m_wear [PHYS_ROWS*PHYS_COLS];
  logic [5:0]  m_map [LOG_ROWS];
  logic [5:0]  m_spare [SPARE_ROWS];
  int          m_spare_head;
  logic [16:0] m_rename_cnt;
  logic        c_ren;
  logic [15:0] c_period;
  logic [5:0]  c_full;
  logic [31:0] c_budget;

  gate_result_t expected_q[$];
  int     errors = 0;
  int     results_seen = 0;
  int     renames_seen = 0;
  longint cycles = 0;
  bit     stim_done = 0;
  bit     hold_out = 0;
  bit     no_idle = 0;

  function automatic logic [5:0] phys_of(logic [5:0] lrow);
    if (c_ren) return m_map[lrow % LOG_ROWS];
    return lrow;
  endfunction

  function automatic gate_result_t predict_gate(gate_beat_t b);
    gate_result_t r;
    logic [5:0]  pt;
    logic [31:0] val;
    logic [31:0] a;
    logic [31:0] bb;
    logic [5:0]  old;
    int          n;
    r.rd = '0;
    r.worn = '0;
    if (b.op > OP_READ || b.rt >= LOG_ROWS) return r;
    if (b.op <= OP_AND && b.ra >= LOG_ROWS) return r;
    if ((b.op == OP_NAND || b.op == OP_AND) && b.rb >= LOG_ROWS) return r;
    if (b.op == OP_READ) begin
      pt = phys_of(b.rt);
      r.rd = m_cells[pt] & b.mask;
    end else begin
      n = $countones(b.mask);
      if (c_ren && n >= c_full) begin
        m_rename_cnt = m_rename_cnt + 17'd1;
        if (m_rename_cnt >= {1'b0, c_period}) begin
          m_rename_cnt = '0;
          old = m_map[b.rt];
          m_map[b.rt] = m_spare[m_spare_head];
          m_spare[m_spare_head] = old;
          m_spare_head = (m_spare_head + 1) % SPARE_ROWS;
          renames_seen++;
        end
      end
      pt = phys_of(b.rt);
      if (b.op == OP_WRITE) begin
        val = b.wbits;
      end else begin
        a = m_cells[phys_of(b.ra)];
        bb = (b.op == OP_NOT) ? 32'd0 : m_cells[phys_of(b.rb)];
        if (b.op == OP_NOT) val = ~a;
        else if (b.op == OP_NAND) val = ~(a & bb);
        else val = a & bb;
      end
      m_cells[pt] = (m_cells[pt] & ~b.mask) | (val & b.mask);
      for (int c = 0; c < PHYS_COLS; c++)
        if (b.mask[c] && m_wear[pt*PHYS_COLS+c] < c_budget)
          m_wear[pt*PHYS_COLS+c]++;
    end
    for (int c = 0; c < PHYS_COLS; c++)
      if (b.mask[c] && m_wear[pt*PHYS_COLS+c] >= c_budget) r.worn[c] = 1'b1;
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_RENAME_EN: c_ren = data[0];
      CFG_PERIOD:    c_period = data[15:0];
      CFG_FULL_COLS: c_full = data[5:0];
      default:       c_budget = data;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    // rejected beats produce results too, so only the back end latency remains
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_beat(gate_beat_t b);
    gate_result_t r;
    // the caller leaves us on a falling edge
    if (!no_idle) while ($urandom_range(99) < 26) @(negedge clk_i);
    in_ch.valid      = 1'b1;
    in_ch.op         <= b.op;
    in_ch.col_mask   <= b.mask;
    in_ch.src_row_a  <= b.ra;
    in_ch.src_row_b  <= b.rb;
    in_ch.target_row <= b.rt;
    in_ch.write_bits <= b.wbits;
    do @(posedge clk_i); while (!in_ch.ready);
    r = predict_gate(b);
    if (b.chk && (r.rd !== b.exp_rd || r.worn !== b.exp_worn)) begin
      $display("%0t: table row disagrees with model: exp %h/%h model %h/%h",
               $time, b.exp_rd, b.exp_worn, r.rd, r.worn);
      errors++;
    end
    expected_q = {expected_q, r};
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  function automatic gate_beat_t mk(logic [2:0] op, logic [31:0] mask, logic [5:0] ra,
                                    logic [5:0] rb, logic [5:0] rt, logic [31:0] wb,
                                    logic chk = 0, logic [31:0] erd = 0,
                                    logic [31:0] ewn = 0);
    gate_beat_t b;
    b.op = op; b.mask = mask; b.ra = ra; b.rb = rb; b.rt = rt; b.wbits = wb;
    b.chk = chk; b.exp_rd = erd; b.exp_worn = ewn;
    return b;
  endfunction

  function automatic gate_beat_t rand_beat(bit well_formed);
    gate_beat_t b;
    logic [31:0] m;
    case ($urandom_range(3))
      0: m = 32'hFFFF_FFFF;
      1: m = $urandom() & $urandom();
      2: m = 32'd1 << $urandom_range(31);
      default: m = $urandom();
    endcase
    b = mk($urandom_range(4), m, $urandom_range(59), $urandom_range(59),
           $urandom_range(59), $urandom());
    if (!well_formed) begin
      b.op = $urandom_range(7);
      b.ra = $urandom_range(63);
      b.rb = $urandom_range(63);
      b.rt = $urandom_range(63);
    end
    return b;
  endfunction

  gate_beat_t directed_tbl[$];

  function automatic void add_row(gate_beat_t b);
    directed_tbl = {directed_tbl, b};
  endfunction

  // result side: random stall, plus one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (hold_out) out_ch.ready <= 1'b0;
    else if (no_idle) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 26);
  end

  initial begin
    int hold_cycles;
    wait (stim_done == 0 && rst_ni);
    repeat (300) @(posedge clk_i);
    hold_out = 1'b1;
    hold_cycles = 0;
    while (hold_cycles < 150) begin
      @(posedge clk_i);
      hold_cycles++;
    end
    hold_out = 1'b0;
  end

  always @(posedge clk_i) begin
    gate_result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat rd=%h worn=%h", $time,
                 out_ch.read_bits, out_ch.worn_mask);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.read_bits !== e.rd) begin
          $display("%0t: read_bits exp %h got %h", $time, e.rd, out_ch.read_bits);
          errors++;
        end
        if (out_ch.worn_mask !== e.worn) begin
          $display("%0t: worn_mask exp %h got %h", $time, e.worn, out_ch.worn_mask);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 0; in_ch.op = 0; in_ch.col_mask = 0; in_ch.src_row_a = 0;
    in_ch.src_row_b = 0; in_ch.target_row = 0; in_ch.write_bits = 0;
    cfg_ch.valid = 0; cfg_ch.index = CFG_RENAME_EN; cfg_ch.data = 0;
    out_ch.ready = 0;
    for (int i = 0; i < PHYS_ROWS; i++) m_cells[i] = '0;
    for (int i = 0; i < PHYS_ROWS*PHYS_COLS; i++) m_wear[i] = '0;
    for (int i = 0; i < LOG_ROWS; i++) m_map[i] = i;
    for (int i = 0; i < SPARE_ROWS; i++) m_spare[i] = LOG_ROWS + i;
    m_spare_head = 0; m_rename_cnt = '0;
    c_ren = 0; c_period = 100; c_full = 32; c_budget = 1000000;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, reset settings
    add_row(mk(OP_READ, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(OP_READ, 32'hFFFF_FFFF, 0, 0, 59, 0, 1, 0, 0));
    add_row(mk(OP_WRITE, 32'hFFFF_FFFF, 0, 0, 0, 32'hA5A5_5A5A, 1, 0, 0));
    add_row(mk(OP_READ, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 32'hA5A5_5A5A, 0));
    add_row(mk(OP_WRITE, 32'hFFFF_FFFF, 0, 0, 59, 32'hFFFF_FFFF));
    add_row(mk(OP_NOT, 32'hFFFF_FFFF, 0, 63, 1, 0));
    add_row(mk(OP_NAND, 32'h0000_FFFF, 0, 59, 2, 0));
    add_row(mk(OP_AND, 32'hFFFF_0000, 0, 59, 3, 0));
    add_row(mk(OP_AND, 32'h0, 0, 1, 4, 0));
    add_row(mk(OP_NOT, 32'hFFFF_FFFF, 3, 3, 3, 0));
    add_row(mk(5, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(7, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(OP_READ, 32'hFFFF_FFFF, 0, 0, 60, 0, 1, 0, 0));
    add_row(mk(OP_WRITE, 32'hFFFF_FFFF, 0, 0, 63, 32'hFFFF_FFFF, 1, 0, 0));
    add_row(mk(OP_NOT, 32'hFFFF_FFFF, 60, 0, 5, 0, 1, 0, 0));
    add_row(mk(OP_NAND, 32'hFFFF_FFFF, 0, 61, 5, 0, 1, 0, 0));
    add_row(mk(OP_NOT, 32'hFFFF_FFFF, 0, 62, 6, 0));
    add_row(mk(OP_READ, 32'hFFFF_FFFF, 0, 0, 1, 0));
    add_row(mk(OP_READ, 32'h8000_0001, 0, 0, 59, 0, 1, 32'h8000_0001, 0));
    foreach (directed_tbl[i]) send_beat(directed_tbl[i]);
    drain();

    // zero budget: everything reads worn; tiny period with renaming
    write_reg(CFG_BUDGET, 32'd0);
    write_reg(CFG_RENAME_EN, 32'd1);
    write_reg(CFG_PERIOD, 32'd0);
    write_reg(CFG_FULL_COLS, 32'd0);
    @(negedge clk_i);
    send_beat(mk(OP_READ, 32'hFFFF_FFFF, 0, 0, 7, 0, 1, 0, 32'hFFFF_FFFF));
    send_beat(mk(OP_WRITE, 32'h0, 0, 0, 9, 32'h1234));
    send_beat(mk(OP_NOT, 32'hFFFF_FFFF, 9, 0, 9, 0));
    for (int i = 0; i < 200; i++) send_beat(rand_beat($urandom_range(9) != 0));
    drain();

    // phases of random traffic with different settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_BUDGET, 32'd3); write_reg(CFG_PERIOD, 32'd2);
          write_reg(CFG_FULL_COLS, 32'd1);
        end
        1: begin
          write_reg(CFG_BUDGET, 32'hFFFF_FFFF); write_reg(CFG_PERIOD, 32'd65535);
          write_reg(CFG_FULL_COLS, 32'd32);
        end
        2: begin
          write_reg(CFG_RENAME_EN, 32'd0); write_reg(CFG_BUDGET, 32'd40);
          write_reg(CFG_PERIOD, 32'd1);
        end
        3: begin
          write_reg(CFG_RENAME_EN, 32'd1); write_reg(CFG_PERIOD, 32'd5);
          write_reg(CFG_FULL_COLS, 32'd63); write_reg(CFG_BUDGET, 32'd25);
        end
        default: begin
          write_reg(CFG_FULL_COLS, 32'd16); write_reg(CFG_PERIOD, 32'd3);
          no_idle = 1'b1;
        end
      endcase
      @(negedge clk_i);
      for (int i = 0; i < 180; i++) begin
        send_beat(rand_beat($urandom_range(9) != 0));
        // sender waits once per phase, after beat 90, for the block to go empty
        if (i == 90) begin
          while (expected_q.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
      end
      drain();
      no_idle = 1'b0;
    end

    stim_done = 1;
    $display("covered %0d result beats over seven register settings, %0d row renames",
             results_seen, renames_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
